/* design/lzwbc_pkg.sv */
// Package for the LZW byte compressor: shared constants and the controller state type.
// No dependencies; the top level imports it.
`default_nettype none

package lzwbc_pkg;

  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int FIRST_ENTRY      = 256;
  localparam int BYTE_W           = 8;
  localparam int CODE_OUT_W       = 12;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_WAIT,
    ST_SLOT,
    ST_ENTRY,
    ST_MISS,
    ST_FLUSH
  } lzwbc_state_t;

endpackage

`default_nettype wire

/* design/lzwbc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Used for both the hash table and the entry store of the LZW byte compressor.
`default_nettype none

module lzwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* design/lzw_byte_compressor.sv */
// LZW byte compressor. The first byte of a stream only loads the prefix; any other byte takes
// a hash slot read and an entry check per probe, plus a code-emit step when the pair is new.
// The hash table read and then the entry store read set the probe loop length.
// Results sit in an output register, so a new byte is taken while a code waits to be taken.
// rst_n (synchronous) starts a clearing pass over all 2 * 2^clog2(DICT_ENTRIES) hash table
// slots (8192 by default), during which no byte is accepted.
`default_nettype none

module lzw_byte_compressor #(
  parameter int DICT_ENTRIES = lzwbc_pkg::DICT_ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [lzwbc_pkg::BYTE_W-1:0]       in_data_byte,
  input  wire logic                               in_end_of_stream,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [lzwbc_pkg::CODE_OUT_W-1:0]   out_code_word,
  output logic                                    out_last_code,
  output logic                                    out_dictionary_full
);

  import lzwbc_pkg::*;

  localparam int CW  = $clog2(DICT_ENTRIES);   // code width
  localparam int SW  = CW + 1;                 // hash slot index width
  localparam int NFW = CW + 1;                 // next free code, can reach DICT_ENTRIES
  localparam int EW  = CW + BYTE_W + SW;       // entry: prefix, byte, back pointer to slot
  localparam logic [NFW-1:0] FIRST_CODE = NFW'(FIRST_ENTRY);
  localparam logic [NFW-1:0] DICT_LIMIT = NFW'(DICT_ENTRIES);

  lzwbc_state_t state_r, state_nxt;

  logic [SW-1:0]     clr_r, clr_nxt;
  logic [NFW-1:0]    next_free_r, next_free_nxt;
  logic [CW-1:0]     prefix_r, prefix_nxt;
  logic              prefix_valid_r, prefix_valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              eos_r, eos_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [CW-1:0]     code_r, code_nxt;
  logic [CW-1:0]     miss_code_r, miss_code_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_OUT_W-1:0] out_code_r, out_code_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_full_r, out_full_nxt;

  logic          hash_we;
  logic [SW-1:0] hash_waddr, hash_raddr;
  logic [CW-1:0] hash_wdata, hash_rdata;

  logic          ent_we;
  logic [CW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;

  logic [CW-1:0]     ent_prefix;
  logic [BYTE_W-1:0] ent_byte;
  logic [SW-1:0]     ent_slot;
  logic              slot_live, slot_hit, out_free, dict_full;
  logic [SW-1:0]     first_slot;
  logic [CW-1:0]     byte_code;

  lzwbc_ram #(.WIDTH(CW), .DEPTH(2 ** SW)) u_hash_ram (
    .clk     (clk),
    .wr_en   (hash_we),
    .wr_addr (hash_waddr),
    .wr_data (hash_wdata),
    .rd_addr (hash_raddr),
    .rd_data (hash_rdata)
  );

  lzwbc_ram #(.WIDTH(EW), .DEPTH(DICT_ENTRIES)) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ent_wdata),
    .rd_addr (ent_raddr),
    .rd_data (ent_rdata)
  );

  assign ent_prefix = ent_rdata[EW-1 -: CW];
  assign ent_byte   = ent_rdata[SW+BYTE_W-1 -: BYTE_W];
  assign ent_slot   = ent_rdata[SW-1:0];

  // A slot is live only if its code belongs to the current stream and that entry points back
  // to this slot. Stale slots from earlier streams therefore read as empty without clearing.
  assign slot_live = ({1'b0, code_r} >= FIRST_CODE) && ({1'b0, code_r} < next_free_r)
                     && (ent_slot == slot_r);
  assign slot_hit  = slot_live && (ent_prefix == prefix_r) && (ent_byte == byte_r);

  assign first_slot = {prefix_r, 1'b0} ^ {in_data_byte, {(SW-BYTE_W){1'b0}}};
  assign byte_code  = {{(CW-BYTE_W){1'b0}}, byte_r};
  assign out_free   = !out_valid_r || out_ready;
  assign dict_full  = next_free_r >= DICT_LIMIT;

  assign in_ready            = (state_r == ST_WAIT);
  assign out_valid           = out_valid_r;
  assign out_code_word       = out_code_r;
  assign out_last_code       = out_last_r;
  assign out_dictionary_full = out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r          <= '0;
      next_free_r    <= FIRST_CODE;
      prefix_r       <= '0;
      prefix_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      clr_r          <= clr_nxt;
      next_free_r    <= next_free_nxt;
      prefix_r       <= prefix_nxt;
      prefix_valid_r <= prefix_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    eos_r       <= eos_nxt;
    slot_r      <= slot_nxt;
    code_r      <= code_nxt;
    miss_code_r <= miss_code_nxt;
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
    out_full_r  <= out_full_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    clr_nxt          = clr_r;
    next_free_nxt    = next_free_r;
    prefix_nxt       = prefix_r;
    prefix_valid_nxt = prefix_valid_r;
    byte_nxt         = byte_r;
    eos_nxt          = eos_r;
    slot_nxt         = slot_r;
    code_nxt         = code_r;
    miss_code_nxt    = miss_code_r;
    out_valid_nxt    = out_ready ? 1'b0 : out_valid_r;
    out_code_nxt     = out_code_r;
    out_last_nxt     = out_last_r;
    out_full_nxt     = out_full_r;

    hash_we    = 1'b0;
    hash_waddr = slot_r;
    hash_wdata = next_free_r[CW-1:0];
    hash_raddr = first_slot;
    ent_we     = 1'b0;
    ent_waddr  = next_free_r[CW-1:0];
    ent_wdata  = {prefix_r, byte_r, slot_r};
    ent_raddr  = hash_rdata;

    unique case (state_r)
      ST_CLEAR: begin
        hash_we    = 1'b1;
        hash_waddr = clr_r;
        hash_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == {SW{1'b1}}) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (in_valid) begin
          byte_nxt = in_data_byte;
          eos_nxt  = in_end_of_stream;
          slot_nxt = first_slot;
          if (!prefix_valid_r) begin
            prefix_nxt       = {{(CW-BYTE_W){1'b0}}, in_data_byte};
            prefix_valid_nxt = 1'b1;
            state_nxt        = in_end_of_stream ? ST_FLUSH : ST_WAIT;
          end else begin
            state_nxt = ST_SLOT;
          end
        end
      end
      ST_SLOT: begin
        // Hash slot data is back; fetch the entry it names.
        code_nxt  = hash_rdata;
        state_nxt = ST_ENTRY;
      end
      ST_ENTRY: begin
        if (slot_hit) begin
          prefix_nxt = code_r;
          state_nxt  = eos_r ? ST_FLUSH : ST_WAIT;
        end else if (slot_live) begin
          slot_nxt   = slot_r + 1'b1;
          hash_raddr = slot_r + 1'b1;
          state_nxt  = ST_SLOT;
        end else begin
          // Empty slot ends the chain: the pair is new and goes here if there is room.
          if (!dict_full) begin
            hash_we       = 1'b1;
            ent_we        = 1'b1;
            next_free_nxt = next_free_r + 1'b1;
          end
          miss_code_nxt = prefix_r;
          prefix_nxt    = byte_code;
          state_nxt     = ST_MISS;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = CODE_OUT_W'(miss_code_r);
          out_last_nxt  = 1'b0;
          out_full_nxt  = dict_full;
          state_nxt     = eos_r ? ST_FLUSH : ST_WAIT;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_code_nxt     = CODE_OUT_W'(prefix_r);
          out_last_nxt     = 1'b1;
          out_full_nxt     = dict_full;
          next_free_nxt    = FIRST_CODE;
          prefix_nxt       = '0;
          prefix_valid_nxt = 1'b0;
          state_nxt        = ST_WAIT;
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r >= FIRST_CODE) && (next_free_r <= DICT_LIMIT))
    else $error("next free code left its range");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    ent_we |-> (state_r == ST_ENTRY) && !dict_full && hash_we)
    else $error("entry insert without room or without hash slot");

  a_entry_after_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENTRY) |-> ($past(state_r) == ST_SLOT))
    else $error("entry check without a preceding slot read");

  a_flush_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) && out_free |=>
      (next_free_r == FIRST_CODE) && !prefix_valid_r && out_valid_r && out_last_code)
    else $error("stream end did not reset the dictionary");

endmodule

`default_nettype wire
